FILE: rtl/dmm_pkg.sv
// dmm_pkg: shared widths, event kinds and register indexes for the deadline
// miss monitor. No dependencies; every other file in rtl/ uses it.
`default_nettype none

package dmm_pkg;

    // Field widths
    localparam int TIME_W  = 64;   // absolute time and deadlines
    localparam int CFG_W   = 32;   // relative deadline and period
    localparam int CNT_W   = 8;    // saturating miss counter
    localparam int KIND_W  = 2;
    localparam int CIDX_W  = 2;

    // Default demotion threshold
    localparam int MISS_LIMIT_DEF = 3;

    // Event kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_REPLENISH = 2'd0,
        KIND_CHECK     = 2'd1,
        KIND_ENROLL    = 2'd2,
        KIND_WITHDRAW  = 2'd3
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_REL_DEADLINE = 2'd0,
        CFG_PERIOD       = 2'd1,
        CFG_DEMOTE       = 2'd2,
        CFG_THROTTLE     = 2'd3
    } cfg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/dmm_cfg_if.sv
// dmm_cfg_if: configuration write channel (index, data) with valid/ready.
// Depends on dmm_pkg for widths.
`default_nettype none

interface dmm_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dmm_pkg::CIDX_W-1:0] idx;
    logic [dmm_pkg::CFG_W-1:0]  data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/dmm_evt_if.sv
// dmm_evt_if: input event channel (kind, now) with valid/ready.
// Depends on dmm_pkg for widths.
`default_nettype none

interface dmm_evt_if;
    logic                       valid;
    logic                       ready;
    logic [dmm_pkg::KIND_W-1:0] kind;
    logic [dmm_pkg::TIME_W-1:0] now;

    modport source (output valid, output kind, output now, input ready);
    modport sink   (input valid, input kind, input now, output ready);
endinterface

`default_nettype wire

FILE: rtl/dmm_rpt_if.sv
// dmm_rpt_if: result channel carrying the task state after each event.
// Depends on dmm_pkg for widths.
`default_nettype none

interface dmm_rpt_if;
    logic                      valid;
    logic                      ready;
    logic                      missed;
    logic                      demoted;
    logic [dmm_pkg::TIME_W-1:0] deadline_out;
    logic [dmm_pkg::CNT_W-1:0]  misses;
    logic                      active;

    modport source (output valid, output missed, output demoted,
                    output deadline_out, output misses, output active,
                    input ready);
    modport sink   (input valid, input missed, input demoted,
                    input deadline_out, input misses, input active,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/dmm_div.sv
// dmm_div: radix-2 restoring remainder unit, one dividend bit per cycle.
// Depends on dmm_pkg for the dividend and divisor widths.
`default_nettype none

module dmm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dmm_pkg::TIME_W-1:0] dividend,
    input  wire logic [dmm_pkg::CFG_W-1:0]  divisor,
    output logic                            done,
    output logic [dmm_pkg::CFG_W-1:0]       remainder
);

    localparam int DVD_W = dmm_pkg::TIME_W;
    localparam int DVS_W = dmm_pkg::CFG_W;
    localparam int ICNT_W = $clog2(DVD_W);
    localparam logic [ICNT_W-1:0] LAST_STEP = ICNT_W'(DVD_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ICNT_W-1:0]   cnt_reg, cnt_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;

    logic [DVS_W:0]      trial;
    logic [DVS_W:0]      trial_diff;
    logic                fits;

    // Shift in the next dividend bit and try one subtract
    always_comb
    begin
        trial      = {rem_reg, dvd_reg[DVD_W-1]};
        trial_diff = trial - {1'b0, divisor};
        fits       = (trial >= {1'b0, divisor});
    end

    // Step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = fits ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/deadline_miss_monitor.sv
// deadline_miss_monitor: single-task deadline supervisor (top level).
// Depends on dmm_pkg, dmm_cfg_if, dmm_evt_if, dmm_rpt_if and dmm_div.
//
//   port  | dir  | carries                                        | item
//   ------+------+------------------------------------------------+-----------------
//   cfg   | sink | idx, data                                      | register write
//   evt   | sink | kind, now                                      | one event
//   rpt   | src  | missed, demoted, deadline_out, misses, active  | state after event
//
// An event is accepted, then evaluated; a throttled miss with a nonzero period
// also runs the 64-step remainder loop in dmm_div, then an adjust step and a sum
// step. Reset leaves the task enrolled with no deadline and no misses;
// registers reset to rel_deadline 0, period 1, both flags 0. A result sits in
// the report register until taken; a new event is accepted meanwhile, and its
// evaluation waits until that register frees. Config writes are always taken.
`default_nettype none

module deadline_miss_monitor #(
    parameter int MISS_LIMIT = dmm_pkg::MISS_LIMIT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dmm_cfg_if.sink   cfg,
    dmm_evt_if.sink   evt,
    dmm_rpt_if.source rpt
);

    localparam int TIME_W = dmm_pkg::TIME_W;
    localparam int CFG_W  = dmm_pkg::CFG_W;
    localparam int CNT_W  = dmm_pkg::CNT_W;
    localparam logic [CNT_W-1:0] LIMIT   = CNT_W'(MISS_LIMIT);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_DIV  = 5'b00100,
        S_ADJ  = 5'b01000,
        S_SUM  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [CFG_W-1:0] rel_reg;
    logic [CFG_W-1:0] period_reg;
    logic             demote_reg;
    logic             throttle_reg;

    // Task state
    logic [TIME_W-1:0] abs_reg, abs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              enrolled_reg, enrolled_next;

    // Latched event
    dmm_pkg::kind_t    kind_reg;
    logic [TIME_W-1:0] now_reg;

    // Throttle adjust: period minus remainder
    logic [CFG_W-1:0]  diff_reg, diff_next;

    // Report register
    logic              rpt_valid_reg, rpt_valid_next;
    logic              rpt_missed_reg, rpt_demoted_reg, rpt_active_reg;
    logic [TIME_W-1:0] rpt_deadline_reg;
    logic [CNT_W-1:0]  rpt_misses_reg;

    // Evaluation terms
    logic [TIME_W:0]   overshoot;
    logic              late;
    logic              miss;
    logic [CNT_W-1:0]  cnt_sat;
    logic              demote;
    logic              throttle_div;
    logic [TIME_W-1:0] repl_sum;
    logic              rpt_free;
    logic              publish, pub_missed, pub_demoted;
    logic              div_start, div_done;
    logic [CFG_W-1:0]  div_rem;

    // Config writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_reg      <= '0;
            period_reg   <= CFG_W'(1);
            demote_reg   <= 1'b0;
            throttle_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (dmm_pkg::cfg_idx_t'(cfg.idx))
                dmm_pkg::CFG_REL_DEADLINE: rel_reg      <= cfg.data;
                dmm_pkg::CFG_PERIOD:       period_reg   <= cfg.data;
                dmm_pkg::CFG_DEMOTE:       demote_reg   <= cfg.data[0];
                dmm_pkg::CFG_THROTTLE:     throttle_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Shared terms: one wide subtract gives both the late test and overshoot
    always_comb
    begin
        overshoot    = {1'b0, now_reg} - {1'b0, abs_reg};
        late         = !overshoot[TIME_W] && (overshoot[TIME_W-1:0] != '0);
        miss         = enrolled_reg && (abs_reg != '0) && late;
        cnt_sat      = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        demote       = demote_reg && (cnt_sat >= LIMIT);
        throttle_div = (kind_reg == dmm_pkg::KIND_CHECK) && miss && !demote
                       && throttle_reg && (period_reg != '0);
        repl_sum     = now_reg + TIME_W'(rel_reg);
        rpt_free     = !rpt_valid_reg || rpt.ready;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        abs_next      = abs_reg;
        cnt_next      = cnt_reg;
        enrolled_next = enrolled_reg;
        diff_next     = diff_reg;
        publish       = 1'b0;
        pub_missed    = 1'b0;
        pub_demoted   = 1'b0;
        div_start     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (evt.valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (throttle_div)
                begin
                    cnt_next   = cnt_sat;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else if (rpt_free)
                begin
                    publish    = 1'b1;
                    state_next = S_IDLE;
                    case (kind_reg)
                        dmm_pkg::KIND_REPLENISH:
                        begin
                            if (enrolled_reg)
                                abs_next = repl_sum;
                        end
                        dmm_pkg::KIND_CHECK:
                        begin
                            if (miss)
                            begin
                                pub_missed = 1'b1;
                                cnt_next   = cnt_sat;
                                if (demote)
                                begin
                                    pub_demoted   = 1'b1;
                                    enrolled_next = 1'b0;
                                    abs_next      = '0;
                                end
                                else if (!throttle_reg)
                                    abs_next = repl_sum;
                                // throttling with zero period keeps the deadline
                            end
                        end
                        dmm_pkg::KIND_ENROLL:
                            enrolled_next = 1'b1;
                        default:
                        begin
                            enrolled_next = 1'b0;
                            abs_next      = '0;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_ADJ;
            end
            S_ADJ:
            begin
                // remainder is below period, so this stays positive
                diff_next  = period_reg - div_rem;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // abs + steps*period == now + (period - remainder), mod 2^64
                if (rpt_free)
                begin
                    abs_next   = now_reg + TIME_W'(diff_reg);
                    publish    = 1'b1;
                    pub_missed = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign evt.ready = (state_reg == S_IDLE);

    // Report register valid
    always_comb
    begin
        if (publish)
            rpt_valid_next = 1'b1;
        else if (rpt.ready)
            rpt_valid_next = 1'b0;
        else
            rpt_valid_next = rpt_valid_reg;
    end

    // Control and task state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            abs_reg       <= '0;
            cnt_reg       <= '0;
            enrolled_reg  <= 1'b1;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            abs_reg       <= abs_next;
            cnt_reg       <= cnt_next;
            enrolled_reg  <= enrolled_next;
            rpt_valid_reg <= rpt_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        if (evt.valid && evt.ready)
        begin
            kind_reg <= dmm_pkg::kind_t'(evt.kind);
            now_reg  <= evt.now;
        end
        if (publish)
        begin
            rpt_missed_reg   <= pub_missed;
            rpt_demoted_reg  <= pub_demoted;
            rpt_deadline_reg <= abs_next;
            rpt_misses_reg   <= cnt_next;
            rpt_active_reg   <= enrolled_next;
        end
    end

    assign rpt.valid        = rpt_valid_reg;
    assign rpt.missed       = rpt_missed_reg;
    assign rpt.demoted      = rpt_demoted_reg;
    assign rpt.deadline_out = rpt_deadline_reg;
    assign rpt.misses       = rpt_misses_reg;
    assign rpt.active       = rpt_active_reg;

    // Remainder of overshoot by period
    dmm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (overshoot[TIME_W-1:0]),
        .divisor   (period_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // A task that is not enrolled never holds a deadline
    a_no_deadline_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        !enrolled_reg |-> (abs_reg == '0))
        else $error("deadline held while task not enrolled");

    // The miss counter never goes down
    a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cnt_reg >= $past(cnt_reg)))
        else $error("miss counter decreased");

    // The remainder unit finishes only while waiting for it, below the period
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == S_DIV) && (div_rem < period_reg)))
        else $error("remainder unit finished out of sequence or out of range");

endmodule

`default_nettype wire
